/* sv/pre_pkg.sv */
// Shared types, constants and helper functions of the pose rate estimator.
// No dependencies; every other file of the block imports this package.
package pre_pkg;

    localparam int STAMP_BITS_DEF = 48;
    localparam int CFG_W          = 20;
    localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = 20'd4000;
    localparam logic [15:0] QUAT_ONE = 16'd16384;

    // Position difference, quaternion accumulator and divider widths.
    localparam int DP_W    = 33;
    localparam int ACC_W   = 35;
    localparam int SCALE_W = 23;
    localparam int PROD_W  = ACC_W + SCALE_W;
    localparam int DT_W    = 54;
    localparam int RATE_DT_W = 44;
    localparam int DEN_W   = 56;
    localparam int NUM_W   = 56;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic signed [SCALE_W-1:0] VEL_SCALE  = 23'sd1000000;
    localparam logic signed [SCALE_W-1:0] RATE_SCALE = 23'sd2000000;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ENGAGE,
        KIND_KEEP,
        KIND_UPDATE
    } pre_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUAT,
        ST_FIX,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_FIN
    } pre_state_t;

    typedef struct packed {
        logic        action;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [15:0] quat_w;
        logic [15:0] quat_x;
        logic [15:0] quat_y;
        logic [15:0] quat_z;
        logic [47:0] stamp_us;
    } sample_t;

    typedef struct packed {
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] rate_x;
        logic [31:0] rate_y;
        logic [31:0] rate_z;
        logic        updated;
        logic        ready_res;
    } result_t;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        pre_kind_t              kind;
        logic                   seen;
        logic [2:0][DP_W-1:0]   dp;
        logic [3:0][15:0]       qp;
        logic [3:0][15:0]       qn;
        logic [DT_W-1:0]        dt;
        logic                   vel_zero;
        logic                   rate_zero;
    } job_t;

    // Term k of conj(q_prev) * q_now: k[3:2] picks the component (w, x, y, z),
    // k[1:0] the previous-quaternion element. Returns {subtract, q_now index}.
    function automatic logic [2:0] quat_term(input logic [3:0] k);
        logic [2:0] r;
        case (k)
            4'd0:    r = {1'b0, 2'd0};
            4'd1:    r = {1'b0, 2'd1};
            4'd2:    r = {1'b0, 2'd2};
            4'd3:    r = {1'b0, 2'd3};
            4'd4:    r = {1'b0, 2'd1};
            4'd5:    r = {1'b1, 2'd0};
            4'd6:    r = {1'b1, 2'd3};
            4'd7:    r = {1'b0, 2'd2};
            4'd8:    r = {1'b0, 2'd2};
            4'd9:    r = {1'b0, 2'd3};
            4'd10:   r = {1'b1, 2'd0};
            4'd11:   r = {1'b1, 2'd1};
            4'd12:   r = {1'b0, 2'd3};
            4'd13:   r = {1'b1, 2'd2};
            4'd14:   r = {1'b0, 2'd1};
            4'd15:   r = {1'b1, 2'd0};
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Applies the sign to a rounded quotient magnitude and clamps to 32 bits.
    function automatic logic [31:0] sat_quot(input logic [NUM_W-1:0] q, input logic neg);
        logic [NUM_W-1:0] qn;
        logic [31:0]      r;
        qn = ~q + NUM_W'(1);
        if (neg) begin
            if (q > NUM_W'(64'h8000_0000))
                r = 32'h8000_0000;
            else
                r = qn[31:0];
        end
        else begin
            if (q > NUM_W'(64'h7FFF_FFFF))
                r = 32'h7FFF_FFFF;
            else
                r = q[31:0];
        end
        return r;
    endfunction

endpackage

/* sv/pre_front.sv */
// Front end: takes pose samples and engage requests, keeps the previous pose
// and stamp, and classifies each request for the back end. Uses pre_pkg.
module pre_front
    import pre_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  sample_t          sample,
    output logic             job_valid,
    input  logic             job_ready,
    output job_t             job
);

    logic [CFG_W-1:0]      min_reg;
    logic [2:0][31:0]      last_pos_reg;
    logic [3:0][15:0]      last_q_reg;
    logic [STAMP_BITS-1:0] last_stamp_reg;
    logic                  stamp_valid_reg;
    logic                  seen_reg;

    logic [63:0]           stamp_ext;
    logic [STAMP_BITS-1:0] stamp;
    logic [STAMP_BITS-1:0] dt;
    logic [63:0]           dt_ext;
    logic [2:0][31:0]      pos;
    logic [3:0][15:0]      quat;
    logic                  accept;

    assign stamp_ext = 64'(sample.stamp_us);
    assign stamp     = stamp_ext[STAMP_BITS-1:0];
    assign dt        = stamp - last_stamp_reg;
    assign dt_ext    = 64'(dt);
    assign pos       = {sample.pos_z, sample.pos_y, sample.pos_x};
    assign quat      = {sample.quat_z, sample.quat_y, sample.quat_x, sample.quat_w};

    assign sample_ready = job_ready;
    assign job_valid    = sample_valid;
    assign accept       = sample_valid && job_ready;

    always_comb
    begin
        job.seen      = seen_reg || !sample.action;
        job.qp        = last_q_reg;
        job.qn        = quat;
        job.dt        = dt_ext[DT_W-1:0];
        job.vel_zero  = (dt_ext[63:DT_W] != '0);
        job.rate_zero = (dt_ext[63:RATE_DT_W] != '0);
        for (int i = 0; i < 3; i++)
        begin
            job.dp[i] = $signed({pos[i][31], pos[i]})
                      - $signed({last_pos_reg[i][31], last_pos_reg[i]});
        end
        if (sample.action)
            job.kind = KIND_ENGAGE;
        else if (stamp_valid_reg && (stamp > last_stamp_reg)
                 && (dt >= STAMP_BITS'(min_reg)))
            job.kind = KIND_UPDATE;
        else
            job.kind = KIND_KEEP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg         <= MIN_INTERVAL_RESET;
            last_pos_reg    <= '0;
            last_q_reg      <= {16'd0, 16'd0, 16'd0, QUAT_ONE};
            last_stamp_reg  <= '0;
            stamp_valid_reg <= 1'b0;
            seen_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                min_reg <= cfg_wdata;
            if (accept)
            begin
                if (sample.action)
                    stamp_valid_reg <= 1'b0;
                else
                begin
                    last_pos_reg    <= pos;
                    last_q_reg      <= quat;
                    last_stamp_reg  <= stamp;
                    stamp_valid_reg <= 1'b1;
                    seen_reg        <= 1'b1;
                end
            end
        end
    end

endmodule

/* sv/pre_queue.sv */
// Two-entry request queue between the front end and the back end.
// Uses job_t and QUEUE_DEPTH from pre_pkg.
module pre_queue
    import pre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* sv/pre_back.sv */
// Back end: quaternion product, scaling multiplies and a bit-serial rounded
// divider that refresh the velocity and rate estimates. Uses pre_pkg.
module pre_back
    import pre_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    pre_state_t state_reg, state_next;

    job_t                    job_reg;
    logic [3:0]              k_reg;
    logic [2:0]              ch_reg;
    logic [DIV_CNT_W-1:0]    bit_reg;
    logic signed [ACC_W-1:0] acc_reg [4];
    logic signed [PROD_W-1:0] prod_reg;
    logic                    neg_reg;
    logic                    zero_reg;
    logic [NUM_W-1:0]        n_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        q_reg;
    logic [2:0][31:0]        vel_reg;
    logic [2:0][31:0]        rate_reg;
    logic                    upd_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic                    slot_free;
    logic                    load_out;
    logic [2:0]              term;
    logic signed [31:0]      qprod;
    logic [1:0]              acc_sel;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [SCALE_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0]       mag_full;
    logic [DEN_W-1:0]        den_c;
    logic [DEN_W:0]          rem_sh;
    logic [31:0]             quot;

    assign slot_free = !out_valid_reg || result_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && slot_free)
                    state_next = (job.kind == KIND_UPDATE) ? ST_QUAT : ST_FIN;
            end
            ST_QUAT:  if (k_reg == 4'd15) state_next = ST_FIX;
            ST_FIX:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_PREP;
            ST_PREP:
            begin
                if ((ch_reg < 3'd3) ? job_reg.vel_zero : job_reg.rate_zero)
                    state_next = ST_STORE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:   if (bit_reg == DIV_CNT_W'(NUM_W - 1)) state_next = ST_STORE;
            ST_STORE: state_next = (ch_reg == 3'd5) ? ST_FIN : ST_MUL;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        job_ready = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: job_ready = slot_free;
            ST_FIN:  load_out  = 1'b1;
            default:
            begin
                job_ready = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    assign term     = quat_term(k_reg);
    assign qprod    = $signed(job_reg.qp[k_reg[1:0]]) * $signed(job_reg.qn[term[1:0]]);
    assign acc_sel  = 2'(ch_reg - 3'd2);
    assign mul_a    = (ch_reg < 3'd3) ? ACC_W'($signed(job_reg.dp[ch_reg[1:0]]))
                                      : acc_reg[acc_sel];
    assign mul_b    = (ch_reg < 3'd3) ? VEL_SCALE : RATE_SCALE;
    assign prod_c   = mul_a * mul_b;
    assign mag_full = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign den_c    = (ch_reg < 3'd3) ? DEN_W'(job_reg.dt)
                                      : {job_reg.dt[RATE_DT_W-1:0], 12'd0};
    assign rem_sh   = {rem_reg, n_reg[NUM_W-1]};
    assign quot     = zero_reg ? 32'd0 : sat_quot(q_reg, neg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Estimates are model state and are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg  <= '0;
            rate_reg <= '0;
            upd_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_IDLE && job_valid && job_ready)
            begin
                upd_reg <= (job.kind == KIND_UPDATE);
                if (job.kind == KIND_ENGAGE)
                    vel_reg <= '0;
            end
            if (state_reg == ST_STORE)
            begin
                if (ch_reg < 3'd3)
                    vel_reg[ch_reg[1:0]] <= quot;
                else
                    rate_reg[acc_sel - 2'd1] <= quot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job;
                k_reg   <= '0;
                ch_reg  <= '0;
                for (int i = 0; i < 4; i++)
                    acc_reg[i] <= '0;
            end
            ST_QUAT:
            begin
                if (term[2])
                    acc_reg[k_reg[3:2]] <= acc_reg[k_reg[3:2]] - ACC_W'(qprod);
                else
                    acc_reg[k_reg[3:2]] <= acc_reg[k_reg[3:2]] + ACC_W'(qprod);
                k_reg <= k_reg + 4'd1;
            end
            ST_FIX:
            begin
                // Take the shorter rotation: flip the vector part when w < 0.
                if (acc_reg[0] < 0)
                begin
                    for (int i = 1; i < 4; i++)
                        acc_reg[i] <= -acc_reg[i];
                end
            end
            ST_MUL:
                prod_reg <= prod_c;
            ST_PREP:
            begin
                neg_reg  <= prod_reg[PROD_W-1];
                zero_reg <= (ch_reg < 3'd3) ? job_reg.vel_zero : job_reg.rate_zero;
                n_reg    <= mag_full[NUM_W-1:0] + (den_c >> 1);
                den_reg  <= den_c;
                rem_reg  <= '0;
                q_reg    <= '0;
                bit_reg  <= '0;
            end
            ST_DIV:
            begin
                n_reg   <= n_reg << 1;
                bit_reg <= bit_reg + 1'b1;
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= DEN_W'(rem_sh - {1'b0, den_reg});
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[DEN_W-1:0];
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
            end
            ST_STORE:
                ch_reg <= ch_reg + 3'd1;
            default:
                k_reg <= k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.vel_x     <= vel_reg[0];
            out_reg.vel_y     <= vel_reg[1];
            out_reg.vel_z     <= vel_reg[2];
            out_reg.rate_x    <= rate_reg[0];
            out_reg.rate_y    <= rate_reg[1];
            out_reg.rate_z    <= rate_reg[2];
            out_reg.updated   <= upd_reg;
            out_reg.ready_res <= job_reg.seen;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* sv/pose_rate_estimator.sv */
// Top level of the pose rate estimator: front end, request queue, back end.
// Depends on pre_pkg, pre_front, pre_queue and pre_back.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+-----------
//   sample    | sample_valid / sample_ready  | sample_t
//   result    | result_valid / result_ready  | result_t
//   config    | cfg_we (no wait)             | cfg_wdata
//
// A request that refreshes the estimates runs in the back end through the 16
// quaternion product terms, then six channels of one multiply and a
// bit-serial divider each. Engage and keep requests skip the arithmetic.
// The front end accepts while the two-entry queue has room, and the result
// register holds its request while result_ready is low. Reset clears control
// and estimate state at once; there is no clearing pass.
module pose_rate_estimator
    import pre_pkg::*;
#(
    parameter int STAMP_BITS = STAMP_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  sample_t          sample,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result
);

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    pre_front #(
        .STAMP_BITS (STAMP_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    pre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_job)
    );

    pre_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (qb_valid),
        .job_ready    (qb_ready),
        .job          (qb_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* sv/pre_checker.sv */
// Port-level checks of the pose rate estimator, bound to the top level.
// Depends on pre_pkg and pose_rate_estimator.
module pre_checker
    import pre_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input sample_t          sample,
    input logic             result_valid,
    input logic             result_ready,
    input result_t          result
);

    logic seen_reg;

    // Remembers that a delivered result already reported a stored pose.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (result_valid && result_ready && result.ready_res)
            seen_reg <= 1'b1;
    end

    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid && $stable(sample))
        else $error("request changed while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_update_needs_pose: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.updated |-> result.ready_res)
        else $error("update reported before any pose was stored");

    a_ready_res_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seen_reg |-> result.ready_res)
        else $error("ready_res dropped after a pose was stored");

endmodule

bind pose_rate_estimator pre_checker u_checker (.*);

/* tb/pose_rate_estimator_test.sv */
// Self-checking bench for pose_rate_estimator: random pose and engage requests with
// a fixed-point predictor of velocity and body rate. Depends on pre_pkg and the RTL.
`timescale 1ns / 100ps

module pose_rate_estimator_test;
    import pre_pkg::*;

    localparam int    MAX_CYCLES = 4000000;
    localparam int    DRAIN_CYCLES = 500;
    localparam bit    ACT_POSE = 1'b0;
    localparam bit    ACT_ENGAGE = 1'b1;
    localparam logic [47:0] STAMP_MAX = 48'hFFFF_FFFF_FFFF;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             sample_valid = 1'b0;
    logic             sample_ready;
    sample_t          sample = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;

    pose_rate_estimator uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    always #1 clk = ~clk;

    // Predictor state.
    logic signed [31:0] prev_pos [3];
    logic signed [15:0] prev_att [4];
    logic [47:0]        prev_stamp;
    logic signed [31:0] vel_est [3];
    logic signed [31:0] rate_est [3];
    logic               seen_pose;
    logic               have_stamp;
    logic [19:0]        min_dt;

    sample_t pending_samples [$];
    result_t expected_results [$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      hold_sender = 1'b0;

    function automatic logic signed [31:0] round_div_sat(input logic signed [127:0] num,
                                                         input logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (num < 0) ? 128'(-num) : 128'(num);
        q = (mag + den / 2) / den;
        if (num < 0)
            return (q > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
        return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
    endfunction

    task automatic predict_result(input sample_t s);
        logic signed [63:0] qn [4];
        logic signed [63:0] a [4];
        logic signed [63:0] rw;
        logic signed [63:0] v [3];
        logic signed [31:0] p [3];
        logic [63:0]        dt;
        result_t            r;
        bit                 upd;
        upd = 1'b0;
        if (s.action == ACT_ENGAGE) begin
            for (int i = 0; i < 3; i++) vel_est[i] = 0;
            have_stamp = 1'b0;
        end
        else begin
            p[0] = s.pos_x; p[1] = s.pos_y; p[2] = s.pos_z;
            qn[0] = 64'($signed(s.quat_w)); qn[1] = 64'($signed(s.quat_x));
            qn[2] = 64'($signed(s.quat_y)); qn[3] = 64'($signed(s.quat_z));
            if (seen_pose && have_stamp && s.stamp_us > prev_stamp) begin
                dt = 64'(s.stamp_us - prev_stamp);
                if (dt >= 64'(min_dt)) begin
                    for (int i = 0; i < 4; i++) a[i] = 64'(prev_att[i]);
                    rw = a[0]*qn[0] + a[1]*qn[1] + a[2]*qn[2] + a[3]*qn[3];
                    v[0] = a[0]*qn[1] - a[1]*qn[0] - a[2]*qn[3] + a[3]*qn[2];
                    v[1] = a[0]*qn[2] + a[1]*qn[3] - a[2]*qn[0] - a[3]*qn[1];
                    v[2] = a[0]*qn[3] - a[1]*qn[2] + a[2]*qn[1] - a[3]*qn[0];
                    if (rw < 0)
                        for (int i = 0; i < 3; i++) v[i] = -v[i];
                    for (int i = 0; i < 3; i++) begin
                        vel_est[i] = round_div_sat(
                            (128'(p[i]) - 128'(prev_pos[i])) * 1000000, 128'(dt));
                        rate_est[i] = round_div_sat(128'(v[i]) * 2000000,
                                                    128'(dt) << 12);
                    end
                    upd = 1'b1;
                end
            end
            for (int i = 0; i < 3; i++) prev_pos[i] = p[i];
            for (int i = 0; i < 4; i++) prev_att[i] = 16'(qn[i]);
            prev_stamp = s.stamp_us;
            have_stamp = 1'b1;
            seen_pose = 1'b1;
        end
        r.vel_x = vel_est[0]; r.vel_y = vel_est[1]; r.vel_z = vel_est[2];
        r.rate_x = rate_est[0]; r.rate_y = rate_est[1]; r.rate_z = rate_est[2];
        r.updated = upd;
        r.ready_res = seen_pose;
        expected_results.push_back(r);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_quat();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'sd16384;
        if (roll == 1) return -16'sd16384;
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Pose near a moving track so that most intervals update the estimates.
    function automatic sample_t make_pose(input logic [47:0] stamp);
        sample_t s;
        int      mode;
        s = '0;
        s.action = ACT_POSE;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            s.pos_x = 32'($signed(prev_pos[0]) + $signed($urandom_range(0, 8191)) - 4096);
            s.pos_y = 32'($signed(prev_pos[1]) + $signed($urandom_range(0, 8191)) - 4096);
            s.pos_z = 32'($signed(prev_pos[2]) + $signed($urandom_range(0, 8191)) - 4096);
        end
        else begin
            s.pos_x = $urandom; s.pos_y = $urandom; s.pos_z = $urandom;
        end
        s.quat_w = rand_quat(); s.quat_x = rand_quat();
        s.quat_y = rand_quat(); s.quat_z = rand_quat();
        s.stamp_us = stamp;
        return s;
    endfunction

    task automatic queue_sample(input sample_t s);
        pending_samples.push_back(s);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_interval(input logic [19:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        min_dt = value;
    endtask

    // Model state while filling runs ahead of the block, so the fill loop
    // tracks the stamp on its own; predictions are made at acceptance.
    logic [47:0] track_stamp;

    initial begin
        sample_t s;
        logic [19:0] settings [5];
        for (int i = 0; i < 3; i++)
        begin
            prev_pos[i] = 0; vel_est[i] = 0; rate_est[i] = 0;
        end
        prev_att[0] = 16'sd16384; prev_att[1] = '0; prev_att[2] = '0; prev_att[3] = '0;
        prev_stamp = '0; seen_pose = 1'b0; have_stamp = 1'b0; min_dt = 20'd4000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first sample only stores, extremes, engage, short, zero,
        // negative and very long intervals, non-unit quaternions.
        s = '0; s.stamp_us = 48'd1000; s.quat_w = 16'sd16384; queue_sample(s);
        s.pos_x = 32'h7FFF_FFFF; s.pos_y = 32'h8000_0000; s.pos_z = 32'hFFFF_FFFF;
        s.quat_w = -16'sd16384; s.stamp_us = 48'd5000; queue_sample(s);
        s.pos_x = 32'h8000_0000; s.pos_y = 32'h7FFF_FFFF; s.pos_z = 0;
        s.quat_w = 0; s.quat_x = 16'sd16384; s.stamp_us = 48'd5001; queue_sample(s);
        s.pos_x = 32'h8000_0000; s.quat_x = -16'sd16384; s.quat_y = 16'sd16384;
        s.quat_z = -16'sd16384; s.stamp_us = 48'd10000; queue_sample(s);
        s.stamp_us = 48'd10000; queue_sample(s);
        s.stamp_us = 48'd9000; queue_sample(s);
        s.stamp_us = 48'd20000; s.pos_y = 32'h1234_5678; queue_sample(s);
        s = '0; s.action = ACT_ENGAGE; s.pos_x = $urandom; s.stamp_us = STAMP_MAX;
        queue_sample(s);
        s = '0; s.stamp_us = 48'd30000; s.pos_x = 32'h0001_0000; s.quat_w = 16'sd16384;
        queue_sample(s);
        s.stamp_us = 48'd40000; s.pos_x = 32'h0002_0000; s.quat_x = 16'sd100;
        queue_sample(s);
        s.stamp_us = STAMP_MAX; s.quat_x = 16'sd3; queue_sample(s);
        s.stamp_us = 0; queue_sample(s);
        s.stamp_us = STAMP_MAX; queue_sample(s);
        s.stamp_us = 48'd123; s.quat_w = 16'sd1234; s.quat_y = -16'sd777; queue_sample(s);
        s.stamp_us = 48'd4123; s.quat_w = -16'sd50; s.quat_z = 16'sd9999; queue_sample(s);
        wait_idle();

        settings[0] = 20'd0; settings[1] = 20'hFFFFF; settings[2] = 20'd1;
        settings[3] = 20'd4000; settings[4] = 20'd500;
        track_stamp = 48'd100000;
        for (int phase = 0; phase < 5; phase++) begin
            write_min_interval(settings[phase]);
            for (int n = 0; n < 400; n++) begin
                int roll;
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    s = '0; s.action = ACT_ENGAGE;
                    s.pos_x = $urandom; s.stamp_us = 48'({$urandom, $urandom});
                end
                else if (roll < 10) begin
                    s = make_pose(48'({$urandom, $urandom}));
                    s.pos_x = $urandom;
                end
                else begin
                    if ($urandom_range(0, 3) == 0)
                        track_stamp = track_stamp + $urandom_range(0, 3000);
                    else
                        track_stamp = track_stamp + $urandom_range(0, 1100000);
                    s = make_pose(track_stamp);
                end
                if (s.action == ACT_POSE && s.stamp_us != track_stamp)
                    track_stamp = s.stamp_us;
                queue_sample(s);
                if (n == 200 && phase == 2) begin
                    // Let part of the backlog go out, then stop the sender
                    // with requests still pending until every result is back.
                    while (pending_samples.size() > 50)
                        @(posedge clk);
                    hold_sender = 1'b1;
                    while (expected_results.size() != 0 || sample_valid)
                        @(posedge clk);
                    hold_sender = 1'b0;
                end
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    int send_gap = 0;
    int recv_gap = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if (sample_valid && sample_ready) begin
                predict_result(sample);
                void'(pending_samples.pop_front());
            end
            if (sample_valid && !sample_ready) begin
                // Hold the request unchanged until it is taken.
            end
            else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0 && !hold_sender) begin
                sample_valid <= 1'b1;
                sample <= pending_samples[0];
                send_gap <= pick_gap();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    always @(posedge clk) begin
        result_t e;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", result);
                end
                else begin
                    e = expected_results.pop_front();
                    if (e !== result) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %h got %h", e, result);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                result_ready <= 1'b0;
            end
            else begin
                result_ready <= 1'b1;
                if (result_valid && result_ready)
                    recv_gap <= pick_gap();
            end
        end
    end

endmodule
